/* design/rmvs_pkg.sv */
// rmvs_pkg: shared types, widths and op codes for the running mean/variance block
// no dependencies
package rmvs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 32;
    localparam int SUM_BITS    = 48;
    localparam int SQ_BITS     = 64;
    localparam int MAG_BITS    = SUM_BITS;
    localparam int PROD_BITS   = 2 * MAG_BITS;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;
    localparam int DIV_BW      = 7; // divider bit counter, up to PROD_BITS-1

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REPORT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // snapshot of the accumulators handed to the back end
    typedef struct packed {
        logic                  neg;
        logic [MAG_BITS-1:0]   mag;
        logic [SQ_BITS-1:0]    sq;
        logic [COUNT_BITS-1:0] cnt;
        logic                  var_en;
        logic                  is_report;
    } t_job;

    typedef struct packed {
        logic [15:0] mean;
        logic [31:0] variance;
        logic [31:0] sample_total;
        logic        is_report;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DIV_MEAN,
        ST_DIV_SQ,
        ST_DIV_VAR,
        ST_OUT
    } t_be_state;

endpackage

/* design/rmvs_front.sv */
// rmvs_front: accumulates samples and issues snapshot/report jobs
// depends on rmvs_pkg
module rmvs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_op,
    input  logic [15:0]           i_sample,
    input  logic                  i_stat_kind,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output rmvs_pkg::t_job        o_job
);
    import rmvs_pkg::*;

    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [SQ_BITS-1:0]    r_sq, n_sq;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [COUNT_BITS:0]   r_next, n_next;
    logic                  acc;
    logic                  emit;
    logic                  is_rep;
    logic [SAMPLE_BITS-1:0] smag;
    logic [SUM_BITS-1:0]   sext;
    logic                  sum_neg;
    t_op                   op;

    assign op      = t_op'(i_op);
    assign o_ready = i_job_ready;
    assign acc     = i_valid && o_ready;

    always_comb begin
        n_sum  = r_sum;
        n_sq   = r_sq;
        n_cnt  = r_cnt;
        n_next = r_next;
        emit   = 1'b0;
        is_rep = 1'b0;
        sext   = {{(SUM_BITS-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample};
        smag   = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
        unique case (op)
            OP_ADD: begin
                if (r_cnt != {COUNT_BITS{1'b1}}) begin
                    n_sum = r_sum + sext;
                    n_sq  = r_sq + SQ_BITS'(smag * smag);
                    n_cnt = r_cnt + 1'b1;
                    if ({1'b0, n_cnt} == r_next) begin
                        n_next = {r_next[COUNT_BITS-1:0], 1'b0};
                        emit   = 1'b1;
                    end
                end
            end
            OP_REPORT: begin
                emit   = 1'b1;
                is_rep = 1'b1;
            end
            OP_CLEAR: begin
                n_sum  = '0;
                n_sq   = '0;
                n_cnt  = '0;
                n_next = (COUNT_BITS+1)'(1);
            end
            default: ;
        endcase
        sum_neg = n_sum[SUM_BITS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_sq   <= '0;
            r_cnt  <= '0;
            r_next <= (COUNT_BITS+1)'(1);
        end else if (acc) begin
            r_sum  <= n_sum;
            r_sq   <= n_sq;
            r_cnt  <= n_cnt;
            r_next <= n_next;
        end
    end

    assign o_job_valid     = acc && emit;
    assign o_job.neg       = sum_neg;
    assign o_job.mag       = sum_neg ? (~n_sum + 1'b1) : n_sum;
    assign o_job.sq        = n_sq;
    assign o_job.cnt       = n_cnt;
    assign o_job.var_en    = i_stat_kind;
    assign o_job.is_report = is_rep;

endmodule

/* design/rmvs_queue.sv */
// rmvs_queue: small fifo of jobs between front and back end
// depends on rmvs_pkg
module rmvs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rmvs_pkg::t_job i_job,
    output logic           o_not_full,
    output logic           o_valid,
    input  logic           i_pop,
    output rmvs_pkg::t_job o_job
);
    import rmvs_pkg::*;

    t_job          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_not_full = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_job      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

endmodule

/* design/rmvs_back.sv */
// rmvs_back: squares the sum and runs restoring divisions one bit per cycle
// depends on rmvs_pkg
module rmvs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_pop,
    input  rmvs_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output rmvs_pkg::t_res o_res
);
    import rmvs_pkg::*;

    t_be_state r_st, n_st;
    t_job      r_job;
    logic [PROD_BITS-1:0]  r_num;   // dividend shifting out / quotient shifting in
    logic [COUNT_BITS:0]   r_rem;
    logic [COUNT_BITS:0]   r_div;
    logic [DIV_BW-1:0]     r_bit;
    logic [1:0]            r_part;  // square partial product step
    logic [PROD_BITS-1:0]  r_prod;
    logic [15:0]           r_mean;
    t_res                  r_res;
    logic                  r_oval;

    logic [COUNT_BITS+1:0] trial;
    logic                  ge;
    logic [COUNT_BITS+1:0] sub;
    logic [23:0]           ha, hb;
    logic [47:0]           pp;
    logic [PROD_BITS-1:0]  pp_sh;
    logic [PROD_BITS-1:0]  q;
    logic                  start;

    assign trial = {r_rem, r_num[PROD_BITS-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign sub   = ge ? trial - {1'b0, r_div} : trial;
    assign q     = {r_num[PROD_BITS-2:0], ge};

    // 48x48 square as four 24x24 products
    assign ha    = r_part[1] ? r_job.mag[47:24] : r_job.mag[23:0];
    assign hb    = r_part[0] ? r_job.mag[47:24] : r_job.mag[23:0];
    assign pp    = ha * hb;
    assign pp_sh = PROD_BITS'(pp) << (24 * (32'(r_part[1]) + 32'(r_part[0])));

    assign start = (r_st == ST_IDLE) && i_valid && (!r_oval || i_ready);
    assign o_pop = start;
    assign o_valid = r_oval;
    assign o_res   = r_res;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:     if (start) n_st = ST_DIV_MEAN;
            ST_DIV_MEAN: if (r_bit == '0) n_st = ST_SQUARE;
            ST_SQUARE:   if (r_part == 2'd3) n_st = ST_DIV_SQ;
            ST_DIV_SQ:   if (r_bit == '0) n_st = ST_DIV_VAR;
            ST_DIV_VAR:  if (r_bit == '0) n_st = ST_OUT;
            ST_OUT:      if (!r_oval || i_ready) n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_oval <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_OUT && (!r_oval || i_ready)) r_oval <= 1'b1;
            else if (i_ready) r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_job <= i_job;
                r_num <= PROD_BITS'(i_job.mag) << (PROD_BITS - MAG_BITS);
                r_rem <= '0;
                r_div <= {1'b0, i_job.cnt};
                r_bit <= DIV_BW'(MAG_BITS - 1);
            end
            ST_DIV_MEAN: begin
                r_num <= q;
                r_rem <= sub[COUNT_BITS:0];
                r_bit <= r_bit - 1'b1;
                if (r_bit == '0) begin
                    // quotient sits in the low MAG_BITS of q, saturate to a signed 16-bit integer (Q16.0)
                    if (r_job.cnt == '0) begin
                        r_mean <= '0;
                    end else if (!r_job.neg) begin
                        r_mean <= (q[MAG_BITS-1:0] > MAG_BITS'(32767)) ? 16'h7fff
                                  : q[15:0];
                    end else begin
                        r_mean <= (q[MAG_BITS-1:0] > MAG_BITS'(32768)) ? 16'h8000
                                  : (~q[15:0] + 1'b1);
                    end
                    r_part <= 2'd0;
                    r_prod <= '0;
                end
            end
            ST_SQUARE: begin
                r_part <= r_part + 1'b1;
                if (r_part == 2'd3) begin
                    r_num <= r_prod + pp_sh;
                    r_rem <= '0;
                    r_bit <= DIV_BW'(PROD_BITS - 1);
                end else begin
                    r_prod <= r_prod + pp_sh;
                end
            end
            ST_DIV_SQ: begin
                if (r_bit != '0) begin
                    r_num <= q;
                    r_rem <= sub[COUNT_BITS:0];
                    r_bit <= r_bit - 1'b1;
                end else begin
                    r_num  <= ((q[PROD_BITS-1:SQ_BITS] != '0 || q[SQ_BITS-1:0] > r_job.sq)
                              ? PROD_BITS'(0) : PROD_BITS'(r_job.sq - q[SQ_BITS-1:0]))
                              << (PROD_BITS - SQ_BITS);
                    r_rem  <= '0;
                    r_div  <= {1'b0, r_job.cnt - 1'b1};
                    r_bit  <= DIV_BW'(SQ_BITS - 1);
                end
            end
            ST_DIV_VAR: begin
                r_num <= q;
                r_rem <= sub[COUNT_BITS:0];
                r_bit <= r_bit - 1'b1;
                if (r_bit == '0) begin
                    r_res.mean         <= r_mean;
                    r_res.sample_total <= r_job.cnt;
                    r_res.is_report    <= r_job.is_report;
                    if (!r_job.var_en || r_job.cnt <= COUNT_BITS'(1))
                        r_res.variance <= '0;
                    else if (q[SQ_BITS-1:32] != '0)
                        r_res.variance <= 32'hffff_ffff;
                    else
                        r_res.variance <= q[31:0];
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

endmodule

/* design/running_mean_variance_snapshots_core.sv */
// running mean / sample variance with power-of-two snapshots, top level
// accumulator front end, a job queue and an iterative divide back end
// depends on rmvs_pkg, rmvs_front, rmvs_queue, rmvs_back
//
// input channel s_axis: op and sample; add ops are taken one per cycle while the queue has room.
// a snapshot is formed when the count hits 1, 2, 4, ...; op 1 reports the
// current mean and variance, op 2 clears the statistics, op 3 is ignored.
// output channel m_axis carries mean, variance, sample_total and is_report.
// each snapshot or report passes the back end's mean division, four-step
// 24x24 square, square division and variance division; its restoring divider
// makes one bit per cycle; the back end starts a new job only when idle. up
// to four jobs wait in the queue; when it is full s_axis_tready drops, including for add ops.
// i_stat_kind_we writes stat_kind (reset 1); write it only while idle.
// reset (synchronous, active low) clears sums and count and sets the next
// snapshot point to one. a stalled receiver holds the result register and
// the back end waits; the queue then fills and back-pressures the input.
module running_mean_variance_snapshots_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample[15:0]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // mean[15:0], variance[47:16], sample_total[79:48]
    output logic        m_axis_tuser,   // is_report
    input  logic        i_stat_kind_we,
    input  logic        i_stat_kind
);
    import rmvs_pkg::*;

    logic r_stat_kind;
    logic job_valid, q_not_full, q_valid, q_pop;
    t_job fjob, qjob;
    t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_stat_kind <= 1'b1;
        else if (i_stat_kind_we) r_stat_kind <= i_stat_kind;
    end

    rmvs_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser), .i_sample(s_axis_tdata),
        .i_stat_kind(r_stat_kind),
        .o_job_valid(job_valid), .i_job_ready(q_not_full), .o_job(fjob)
    );

    rmvs_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(job_valid), .i_job(fjob), .o_not_full(q_not_full),
        .o_valid(q_valid), .i_pop(q_pop), .o_job(qjob)
    );

    rmvs_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_pop(q_pop), .i_job(qjob),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {res.sample_total, res.variance, res.mean};
    assign m_axis_tuser = res.is_report;

endmodule

/* dv/running_mean_variance_snapshots_core_tb.sv */
// testbench for running_mean_variance_snapshots_core: directed and random op streams
// with a built-in statistics predictor and a scoreboard; depends on rmvs_pkg and the core
module running_mean_variance_snapshots_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rmvs_pkg::*;

    localparam int LIMIT_CYCLES  = 1500000;
    localparam int DRAIN_CYCLES  = 250;
    localparam int RANDOM_PER_PHASE = 265;
    localparam int NUM_PHASES    = 6;

    typedef struct {
        t_op         op;
        logic [15:0] sample;
    } t_stat_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // sample[15:0]
    logic [1:0]  s_axis_tuser = '0;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;        // mean[15:0], variance[47:16], sample_total[79:48]
    logic        m_axis_tuser;        // is_report
    logic        i_stat_kind_we = 1'b0;
    logic        i_stat_kind = 1'b0;

    running_mean_variance_snapshots_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_stat_kind_we(i_stat_kind_we),
        .i_stat_kind   (i_stat_kind)
    );

    // predictor state
    logic [47:0] acc_sum;
    logic [63:0] acc_sq;
    logic [31:0] acc_cnt;
    logic [32:0] next_stop;
    logic        kind_mv;

    t_stat_item pending_items[$];
    t_res       expected_stats[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         mismatches;
    int         results_seen;
    int         items_sent;
    int         reports_seen;
    longint     cycles;

    function automatic t_res form_stats(logic rep);
        t_res         r;
        logic         neg;
        logic [47:0]  mag;
        logic [47:0]  q;
        logic [127:0] prod;
        logic [127:0] qq;
        logic [63:0]  num;
        logic [63:0]  vr;
        r = '0;
        r.sample_total = acc_cnt;
        r.is_report = rep;
        if (acc_cnt != 0) begin
            neg = acc_sum[47];
            mag = neg ? -acc_sum : acc_sum;
            q = mag / {16'b0, acc_cnt};
            if (!neg) begin
                r.mean = (q > 48'd32767) ? 16'h7fff : q[15:0];
            end else begin
                if (q > 48'd32768) q = 48'd32768;
                r.mean = -q[15:0];
            end
            if (kind_mv && acc_cnt > 1) begin
                prod = {80'b0, mag} * {80'b0, mag};
                qq = prod / {96'b0, acc_cnt};
                num = (qq > {64'b0, acc_sq}) ? 64'd0 : acc_sq - qq[63:0];
                vr = num / {32'b0, acc_cnt - 32'd1};
                r.variance = (vr > 64'hffff_ffff) ? 32'hffff_ffff : vr[31:0];
            end
        end
        return r;
    endfunction

    function automatic void clear_stats();
        acc_sum = '0;
        acc_sq = '0;
        acc_cnt = '0;
        next_stop = 33'd1;
    endfunction

    function automatic void expect_result(t_res r);
        expected_stats = {expected_stats, r};
    endfunction

    function automatic void predict_stats(t_stat_item it);
        logic [47:0] sx;
        logic [16:0] mag;
        case (it.op)
            OP_ADD: begin
                if (acc_cnt != 32'hffff_ffff) begin
                    sx = {{32{it.sample[15]}}, it.sample};
                    mag = it.sample[15] ? -{1'b1, it.sample} : {1'b0, it.sample};
                    acc_sum = acc_sum + sx;
                    acc_sq = acc_sq + {47'b0, mag} * {47'b0, mag};
                    acc_cnt = acc_cnt + 1;
                    if ({1'b0, acc_cnt} == next_stop) begin
                        next_stop = next_stop << 1;
                        expect_result(form_stats(1'b0));
                    end
                end
            end
            OP_REPORT: expect_result(form_stats(1'b1));
            OP_CLEAR:  clear_stats();
            default: ;
        endcase
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout at %0t", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        t_stat_item it;
        logic       load;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            load = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                it.op = t_op'(s_axis_tuser);
                it.sample = s_axis_tdata;
                predict_stats(it);
                items_sent++;
                load = 1'b1;
            end
            if (load) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= it.op;
                    s_axis_tdata <= it.sample;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.mean = m_axis_tdata[15:0];
                got.variance = m_axis_tdata[47:16];
                got.sample_total = m_axis_tdata[79:48];
                got.is_report = m_axis_tuser;
                results_seen++;
                if (got.is_report) reports_seen++;
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_stats.pop_front();
                    if (got.mean !== want.mean) begin
                        $display("%0t: mean expected %h actual %h", $time, want.mean, got.mean);
                        mismatches++;
                    end
                    if (got.variance !== want.variance) begin
                        $display("%0t: variance expected %h actual %h",
                                 $time, want.variance, got.variance);
                        mismatches++;
                    end
                    if (got.sample_total !== want.sample_total) begin
                        $display("%0t: sample_total expected %0d actual %0d",
                                 $time, want.sample_total, got.sample_total);
                        mismatches++;
                    end
                    if (got.is_report !== want.is_report) begin
                        $display("%0t: is_report expected %b actual %b",
                                 $time, want.is_report, got.is_report);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_item(t_op op, logic [15:0] sample);
        t_stat_item it;
        it.op = op;
        it.sample = sample;
        pending_items = {pending_items, it};
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_stats.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_kind(logic v);
        @(posedge i_clk);
        i_stat_kind_we <= 1'b1;
        i_stat_kind <= v;
        @(posedge i_clk);
        i_stat_kind_we <= 1'b0;
        kind_mv = v;
    endtask

    initial begin
        int r;
        logic [15:0] s;
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        reports_seen = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        kind_mv = 1'b1;
        clear_stats();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty report, unused op, extremes, snapshots, clears
        queue_item(OP_REPORT, 16'h0000);
        queue_item(OP_NONE, 16'hffff);
        queue_item(OP_ADD, 16'h7fff);
        queue_item(OP_ADD, 16'h8000);
        queue_item(OP_ADD, 16'h0000);
        queue_item(OP_ADD, 16'h0001);
        queue_item(OP_REPORT, 16'h5a5a);
        queue_item(OP_ADD, 16'hffff);
        queue_item(OP_CLEAR, 16'h0000);
        queue_item(OP_REPORT, 16'h0000);
        queue_item(OP_ADD, 16'h0100);
        queue_item(OP_REPORT, 16'h0000);
        queue_item(OP_CLEAR, 16'hffff);
        for (int k = 0; k < 8; k++)
            queue_item(OP_ADD, (k % 2) ? 16'h8000 : 16'h7fff);
        queue_item(OP_REPORT, 16'h0000);
        queue_item(OP_NONE, 16'h0000);
        queue_item(OP_CLEAR, 16'h0000);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_kind(ph % 2 == 0 ? 1'b0 : 1'b1);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                r = $urandom_range(99);
                case ($urandom_range(3))
                    0: s = $urandom_range(1) ? 16'h7fff : 16'h8000;
                    1: s = 16'($signed($urandom_range(512)) - 256);
                    default: s = 16'($urandom);
                endcase
                if (r < 80)      queue_item(OP_ADD, s);
                else if (r < 92) queue_item(OP_REPORT, s);
                else if (r < 96) queue_item(OP_CLEAR, s);
                else             queue_item(OP_NONE, s);
            end
            wait_idle();
        end

        $display("covered %0d items over %0d phases, both stat kinds and all idle mixes",
                 items_sent, NUM_PHASES + 1);
        $display("checked %0d results, %0d of them reports", results_seen, reports_seen);
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
